// ===== rtl/core/fimbr_pkg.sv =====
// Shared types, constants and helpers for the image marker bit-reverse unit.
`default_nettype none

package fimbr_pkg;

   localparam int LengthBits = 32;
   localparam int SumBits    = LengthBits + 1;

   // marker characters
   localparam logic [7:0] CharE   = 8'h45;
   localparam logic [7:0] CharP   = 8'h50;
   localparam logic [7:0] CharC   = 8'h43;
   localparam logic [7:0] CharS   = 8'h53;
   localparam logic [7:0] Char1   = 8'h31;
   localparam logic [7:0] Char4   = 8'h34;
   localparam logic [7:0] Char6   = 8'h36;

   localparam logic [6:0] SkipAfterMarker = 7'd20;
   localparam logic [6:0] TrailerEpcs4    = 7'd61;
   localparam logic [6:0] TrailerEpcs16   = 7'd66;
   localparam logic [6:0] TrailerEpcs64   = 7'd62;

   typedef logic [LengthBits-1:0] length_type;

   typedef enum logic [2:0] {
      MatchNone,
      MatchE,
      MatchEp,
      MatchEpc,
      MatchEpcs,
      MatchEpcs1,
      MatchEpcs6
   } match_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  out_byte;
      logic        is_payload;
      logic        done_res;
      logic        found;
      logic        bad_length;
      logic [31:0] payload_length;
   } result_type;

   function automatic logic [7:0] reverse_byte(input logic [7:0] b);
      return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fimbr_if.sv =====
// Request and response channel interfaces of the image marker bit-reverse unit.
`default_nettype none

interface fimbr_req_if;
   logic       valid;
   logic       ready;
   logic       frame_start;
   logic [7:0] data_byte;

   modport source (output valid, frame_start, data_byte, input ready);
   modport sink   (input valid, frame_start, data_byte, output ready);
   modport mon    (input valid, ready, frame_start, data_byte);
endinterface

interface fimbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        is_payload;
   logic        done_res;
   logic        found;
   logic        bad_length;
   logic [31:0] payload_length;

   modport source (output valid, out_byte, is_payload, done_res, found, bad_length,
                   payload_length, input ready);
   modport sink   (input valid, out_byte, is_payload, done_res, found, bad_length,
                   payload_length, output ready);
   modport mon    (input valid, ready, out_byte, is_payload, done_res, found, bad_length,
                   payload_length);
endinterface

`default_nettype wire

// ===== rtl/core/fimbr_scan.sv =====
// Marker scanner, payload window tracking and result formation for one byte per beat.
`default_nettype none

module fimbr_scan import fimbr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       frame_start,
   input  wire logic [7:0] data_byte,
   input  wire length_type total_length,
   output result_type      result
);

   length_type pos_ff,   pos_in;
   match_type  match_ff, match_in;
   logic       found_ff, found_in;
   length_type start_ff, start_in;
   length_type end_ff,   end_in;
   logic       err_ff,   err_in;

   // state as seen by this beat, after a frame start clears it
   length_type pos_base;
   match_type  match_base;
   logic       found_base;
   length_type start_base;
   length_type end_base;
   logic       err_base;

   logic                 active;
   logic                 last;
   logic                 in_window;
   logic                 take;
   logic [6:0]           trailer;
   logic [SumBits-1:0]   limit_sum;
   match_type            restart;

   always_comb begin
      if (frame_start) begin
         pos_base   = '0;
         match_base = MatchNone;
         found_base = 1'b0;
         start_base = '0;
         end_base   = '0;
         err_base   = 1'b0;
      end else begin
         pos_base   = pos_ff;
         match_base = match_ff;
         found_base = found_ff;
         start_base = start_ff;
         end_base   = end_ff;
         err_base   = err_ff;
      end

      active    = accept && (pos_base < total_length);
      last      = ({1'b0, pos_base} + SumBits'(1)) == {1'b0, total_length};
      in_window = found_base && !err_base && (pos_base >= start_base) && (pos_base < end_base);
      restart   = (data_byte == CharE) ? MatchE : MatchNone;

      take    = 1'b0;
      trailer = TrailerEpcs4;
      match_in = match_base;
      case (match_base)
         MatchNone:  match_in = restart;
         MatchE:     match_in = (data_byte == CharP) ? MatchEp : restart;
         MatchEp:    match_in = (data_byte == CharC) ? MatchEpc : restart;
         MatchEpc:   match_in = (data_byte == CharS) ? MatchEpcs : restart;
         MatchEpcs: begin
            if (data_byte == Char4) begin
               // the 'E' must sit far enough from the end
               match_in = MatchNone;
               take     = !last;
               trailer  = TrailerEpcs4;
            end else if (data_byte == Char1) begin
               match_in = MatchEpcs1;
            end else if (data_byte == Char6) begin
               match_in = MatchEpcs6;
            end else begin
               match_in = restart;
            end
         end
         MatchEpcs1: begin
            if (data_byte == Char6) begin
               match_in = MatchNone;
               take     = 1'b1;
               trailer  = TrailerEpcs16;
            end else begin
               match_in = restart;
            end
         end
         MatchEpcs6: begin
            if (data_byte == Char4) begin
               match_in = MatchNone;
               take     = 1'b1;
               trailer  = TrailerEpcs64;
            end else begin
               match_in = restart;
            end
         end
         default:    match_in = restart;
      endcase

      limit_sum = {1'b0, pos_base} + SumBits'(SkipAfterMarker) + SumBits'(trailer);

      pos_in   = pos_ff;
      found_in = found_ff;
      start_in = start_ff;
      end_in   = end_ff;
      err_in   = err_ff;
      if (accept) begin
         pos_in   = pos_base;
         found_in = found_base;
         start_in = start_base;
         end_in   = end_base;
         err_in   = err_base;
      end
      if (!accept || !active || found_base) begin
         match_in = accept ? match_base : match_ff;
      end
      if (active) begin
         pos_in = pos_base + LengthBits'(1);
         if (!found_base && take) begin
            found_in = 1'b1;
            if (limit_sum > {1'b0, total_length}) begin
               err_in   = 1'b1;
               start_in = '0;
               end_in   = '0;
            end else begin
               start_in = pos_base + LengthBits'(SkipAfterMarker);
               end_in   = total_length - LengthBits'(trailer);
            end
         end
      end

      // a marker taken on this beat never opens the window on the same beat,
      // and on the last byte it always trips the length check
      result.valid          = active && (in_window || last);
      result.is_payload     = in_window;
      result.out_byte       = in_window ? reverse_byte(data_byte) : 8'h00;
      result.done_res       = !in_window && last;
      result.found          = !in_window && last && found_in;
      result.bad_length     = !in_window && last && err_in;
      result.payload_length = (!in_window && last && found_base && !err_base)
                            ? 32'(end_base - start_base) : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         match_ff <= MatchNone;
         found_ff <= 1'b0;
         start_ff <= '0;
         end_ff   <= '0;
         err_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
         found_ff <= found_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fpga_image_marker_bit_reverse_unit.sv =====
// Top level of the configuration image marker scan and bit-reverse unit.
// Accepts one image byte per beat, every cycle while req_bus is ready, and
// scans for the first EPCS4, EPCS16 or EPCS64 marker; bytes between 20
// past the marker and the variant's trailer come out bit-reversed, and the
// final image byte (at position total_length-1) gives a completion beat
// with found, bad_length and payload_length. Results are registered.
// A two-entry output buffer (output register plus skid) keeps req_bus ready
// while one result waits on rsp_bus; ready drops only when both are full.
// Bytes past the image end and all bytes with total_length of zero give no
// result. Write total_length only while no byte is in flight.
`default_nettype none

module fpga_image_marker_bit_reverse_unit import fimbr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   fimbr_req_if.sink        req_bus,
   fimbr_rsp_if.source      rsp_bus
);

   length_type total_length_ff;
   logic       accept;
   result_type result;

   result_type out_ff,   out_in;
   result_type skid_ff,  skid_in;
   logic       take_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= '0;
      end else if (csr_wr_en) begin
         total_length_ff <= csr_wr_data[LengthBits-1:0];
      end
   end

   assign req_bus.ready = !skid_ff.valid;
   assign accept        = req_bus.valid && req_bus.ready;

   fimbr_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_start  (req_bus.frame_start),
      .data_byte    (req_bus.data_byte),
      .total_length (total_length_ff),
      .result       (result)
   );

   assign take_out = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (take_out) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (!out_ff.valid || take_out) begin
         out_in = result;
      end else if (result.valid) begin
         skid_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         out_ff.valid  <= out_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      out_ff.out_byte        <= out_in.out_byte;
      out_ff.is_payload      <= out_in.is_payload;
      out_ff.done_res        <= out_in.done_res;
      out_ff.found           <= out_in.found;
      out_ff.bad_length      <= out_in.bad_length;
      out_ff.payload_length  <= out_in.payload_length;
      skid_ff.out_byte       <= skid_in.out_byte;
      skid_ff.is_payload     <= skid_in.is_payload;
      skid_ff.done_res       <= skid_in.done_res;
      skid_ff.found          <= skid_in.found;
      skid_ff.bad_length     <= skid_in.bad_length;
      skid_ff.payload_length <= skid_in.payload_length;
   end

   assign rsp_bus.valid          = out_ff.valid;
   assign rsp_bus.out_byte       = out_ff.out_byte;
   assign rsp_bus.is_payload     = out_ff.is_payload;
   assign rsp_bus.done_res       = out_ff.done_res;
   assign rsp_bus.found          = out_ff.found;
   assign rsp_bus.bad_length     = out_ff.bad_length;
   assign rsp_bus.payload_length = out_ff.payload_length;

endmodule

`default_nettype wire

// ===== rtl/core/fimbr_checker.sv =====
// Port-level assertions for the image marker bit-reverse unit, bound to the top level.
`default_nettype none

module fimbr_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_is_payload,
   input  wire logic        rsp_done_res,
   input  wire logic        rsp_found,
   input  wire logic [31:0] rsp_payload_length
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_done_res))
      else $error("rsp beat dropped or changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // output goes valid only from a byte accepted the cycle before
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("rsp beat without an accepted byte");

   // input backpressure only when the output side is full
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req stalled with empty output");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_payload |-> !rsp_done_res && !rsp_found
         && (rsp_payload_length == 32'd0))
      else $error("payload beat carries completion fields");

endmodule

bind fpga_image_marker_bit_reverse_unit fimbr_checker u_fimbr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_out_byte       (rsp_bus.out_byte),
   .rsp_is_payload     (rsp_bus.is_payload),
   .rsp_done_res       (rsp_bus.done_res),
   .rsp_found          (rsp_bus.found),
   .rsp_payload_length (rsp_bus.payload_length)
);

`default_nettype wire
